/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is high.
`define SNFP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define SNFP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/snfp_pkg.sv */
// Types and constants of the scale notification frame parser.
`timescale 1ns / 1ps

package snfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hDF;
  localparam logic [7:0] FUNC_SENSOR = 8'h03;
  localparam logic [7:0] CMD_WEIGHT  = 8'h00;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] MIN_PAYLOAD = 8'd13;
  localparam logic [9:0] MIN_FRAME   = 10'd6;
  localparam logic [8:0] POS_MAX     = 9'd511;
  localparam int         FIFO_DEPTH  = 2;

  typedef enum logic [2:0] {
    ST_WEIGHT    = 3'd0,
    ST_HEARTBEAT = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_SHORT     = 3'd5
  } status_t;

  typedef struct packed {
    logic        frame_ok;
    logic        sum_ok;
    logic        len_ok;
    logic [7:0]  func;
    logic [7:0]  cmd;
    logic [7:0]  length;
    logic [31:0] weight;
    logic [7:0]  battery;
  } frame_rec_t;

endpackage

/* hdl/snfp_front.sv */
// Front end: accepts frame bytes, keeps running frame state, emits one record per frame.
`timescale 1ns / 1ps

module snfp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               rec_push,
  output snfp_pkg::frame_rec_t rec,
  input  logic               rec_full
);
  import snfp_pkg::*;

  logic [8:0]  pos, pos_next;
  logic [7:0]  sum, sum_next;
  logic        hdr, hdr_next;
  logic [7:0]  func, func_next;
  logic [7:0]  cmd, cmd_next;
  logic [7:0]  length, length_next;
  logic [31:0] weight, weight_next;
  logic [7:0]  battery, battery_next;
  logic        accept;
  logic        hdr_upd;
  logic [7:0]  func_upd, cmd_upd, length_upd, battery_upd;
  logic [31:0] weight_upd;

  assign full   = rec_full;
  assign accept = push && !rec_full;

  always_comb begin
    hdr_upd     = hdr && !((pos < 9'd2) && (data_byte != HDR_BYTE));
    func_upd    = (pos == 9'd2) ? data_byte : func;
    cmd_upd     = (pos == 9'd3) ? data_byte : cmd;
    length_upd  = (pos == 9'd4) ? data_byte : length;
    weight_upd  = (pos >= 9'd5 && pos <= 9'd8) ? {weight[23:0], data_byte} : weight;
    battery_upd = (pos == 9'd6) ? data_byte : battery;

    rec.frame_ok = hdr_upd && (pos >= 9'd5);
    rec.sum_ok   = (sum == data_byte);
    rec.len_ok   = ({1'b0, pos} + 10'd1) >= (MIN_FRAME + {2'b00, length_upd});
    rec.func     = func_upd;
    rec.cmd      = cmd_upd;
    rec.length   = length_upd;
    rec.weight   = weight_upd;
    rec.battery  = battery_upd;
    rec_push     = accept && last_byte;

    pos_next     = pos;
    sum_next     = sum;
    hdr_next     = hdr;
    func_next    = func;
    cmd_next     = cmd;
    length_next  = length;
    weight_next  = weight;
    battery_next = battery;
    if (accept) begin
      if (last_byte) begin
        pos_next     = '0;
        sum_next     = '0;
        hdr_next     = 1'b1;
        func_next    = '0;
        cmd_next     = '0;
        length_next  = '0;
        weight_next  = '0;
        battery_next = '0;
      end else begin
        pos_next     = (pos != POS_MAX) ? pos + 9'd1 : pos;
        sum_next     = sum + data_byte;
        hdr_next     = hdr_upd;
        func_next    = func_upd;
        cmd_next     = cmd_upd;
        length_next  = length_upd;
        weight_next  = weight_upd;
        battery_next = battery_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      sum     <= '0;
      hdr     <= 1'b1;
      func    <= '0;
      cmd     <= '0;
      length  <= '0;
      weight  <= '0;
      battery <= '0;
    end else begin
      pos     <= pos_next;
      sum     <= sum_next;
      hdr     <= hdr_next;
      func    <= func_next;
      cmd     <= cmd_next;
      length  <= length_next;
      weight  <= weight_next;
      battery <= battery_next;
    end
  end

endmodule

/* hdl/snfp_fifo.sv */
// Short queue of frame records between front and back.
`timescale 1ns / 1ps

module snfp_fifo #(
  parameter int DEPTH = snfp_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  snfp_pkg::frame_rec_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output snfp_pkg::frame_rec_t rd_data,
  output logic                 valid
);
  import snfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/snfp_back.sv */
// Back end: decodes a frame record into a status and holds the result register.
`timescale 1ns / 1ps

module snfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  snfp_pkg::frame_rec_t rec,
  output logic                 rec_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           status,
  output logic signed [31:0]   weight_tenths,
  output logic [7:0]           battery_level,
  output logic [7:0]           func_code,
  output logic [7:0]           cmd_code
);
  import snfp_pkg::*;

  logic        out_valid;
  logic        load;
  status_t     st_next;
  logic [31:0] weight_next;
  logic [7:0]  battery_next;

  assign empty   = !out_valid;
  assign load    = rec_valid && (!out_valid || pop);
  assign rec_pop = load;

  always_comb begin
    weight_next  = '0;
    battery_next = '0;
    if (!rec.frame_ok) begin
      st_next = ST_BAD_HDR;
    end else if (!rec.sum_ok) begin
      st_next = ST_CHECKSUM;
    end else if (rec.func == FUNC_SENSOR && rec.cmd == CMD_WEIGHT) begin
      if (rec.length >= MIN_PAYLOAD && rec.len_ok) begin
        st_next     = ST_WEIGHT;
        weight_next = rec.weight;
      end else begin
        st_next = ST_SHORT;
      end
    end else if (rec.func == FUNC_SENSOR && rec.cmd == CMD_STATUS) begin
      st_next      = ST_HEARTBEAT;
      battery_next = rec.battery;
    end else begin
      st_next = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= st_next;
      weight_tenths <= weight_next;
      battery_level <= battery_next;
      func_code     <= rec.func;
      cmd_code      <= rec.cmd;
    end
  end

endmodule

/* hdl/scale_notification_frame_parser_unit.sv */
// Top level of the scale notification frame parser.
//
// Input channel: one frame byte per item on data_byte, last_byte set on the
// final (checksum) byte. An item is taken when push is high and full is low.
// Result channel: one result per frame, shown while empty is low and taken
// when pop is high and empty is low. Bytes other than the final one give no
// result.
// Throughput: one byte per cycle while full is low, set by the registered
// running state update in the front end; frames of any length follow each other without gaps.
// Path: the record of a frame is written to the queue when its final byte is
// taken, then loaded into the result register once that register is empty or
// being popped; the result stays on the result ports until it is popped.
// A stalled receiver fills the result register and then the record queue;
// full rises only when the queue holds FIFO_DEPTH records, and then every
// byte is held off until a result is popped.
// Reset (rst, synchronous): clears the frame state and the queue and marks the
// result register empty; empty is high in the cycle after reset.
`timescale 1ns / 1ps

module scale_notification_frame_parser_unit #(
  parameter int FIFO_DEPTH = snfp_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic signed [31:0] weight_tenths,
  output logic [7:0]         battery_level,
  output logic [7:0]         func_code,
  output logic [7:0]         cmd_code
);
  import snfp_pkg::*;

  frame_rec_t front_rec, back_rec;
  logic       rec_push, rec_full, rec_pop, rec_valid;

  snfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .rec_push  (rec_push),
    .rec       (front_rec),
    .rec_full  (rec_full)
  );

  snfp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (front_rec),
    .full    (rec_full),
    .rd_en   (rec_pop),
    .rd_data (back_rec),
    .valid   (rec_valid)
  );

  snfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec           (back_rec),
    .rec_pop       (rec_pop),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .weight_tenths (weight_tenths),
    .battery_level (battery_level),
    .func_code     (func_code),
    .cmd_code      (cmd_code)
  );

endmodule

/* hdl/snfp_checker.sv */
// Port-level checker for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [2:0]         status,
  input logic signed [31:0] weight_tenths,
  input logic [7:0]         battery_level
);
  import snfp_pkg::*;

  `SNFP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result pending after reset")
  `SNFP_ASSERT(a_status_range, clk, rst, !empty |-> (status != 3'd6 && status != 3'd7), "status out of range")
  `SNFP_ASSERT(a_hold_stalled, clk, rst, (!empty && !pop) |=> (!empty && $stable(status) && $stable(weight_tenths)), "stalled result changed")
  `SNFP_ASSERT(a_weight_only, clk, rst, (!empty && status != ST_WEIGHT) |-> (weight_tenths == 32'sd0), "weight set without weight status")
  `SNFP_ASSERT(a_battery_only, clk, rst, (!empty && status != ST_HEARTBEAT) |-> (battery_level == 8'd0), "battery set without heartbeat status")

endmodule

bind scale_notification_frame_parser_unit snfp_checker u_snfp_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .status        (status),
  .weight_tenths (weight_tenths),
  .battery_level (battery_level)
);
